### src/m2rs_pkg.sv
// shared constants, payload structs and controller/datapath interface types
// for the two-dimensional fenwick range sum block; no dependencies
package m2rs_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  // fixed field widths
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;
  localparam int CNT_W = 7;
  localparam int FEN_W = 38;
  localparam int SUM_W = 44;

  // storage geometry
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  // fenwick index, 1-based, must hold values past MAX_COLS during an update walk
  localparam int K_W    = COL_W + 2;

  // config port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic [IDX_W-1:0]        row_a;
    logic [IDX_W-1:0]        col_a;
    logic [IDX_W-1:0]        row_b;
    logic [IDX_W-1:0]        col_b;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] region_sum;
    logic                    index_error;
  } res_t;

  typedef struct packed {
    logic item_load;
    logic clr_step;
    logic acc_clr;
    logic err_latch;
    logic row_init;
    logic row_inc;
    logic k_hi_init;
    logic k_lo_init;
    logic k_upd_init;
    logic k_down;
    logic k_up;
    logic delta_load;
    logic cell_wr;
    logic fen_rd;
    logic fen_sub;
    logic fen_wr;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic k_zero;
    logic k_next_zero;
    logic k_over;
    logic row_last;
    logic q_err;
    logic q_empty;
    logic u_err;
    logic out_free;
  } sts_t;

endpackage

### src/m2rs_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module m2rs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/m2rs_regs.sv
// apb register file: row_count and col_count, with effective limits
// depends on m2rs_pkg
module m2rs_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [m2rs_pkg::APB_AW-1:0]  paddr,
  input  logic [m2rs_pkg::APB_DW-1:0]  pwdata,
  output logic [m2rs_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output logic [m2rs_pkg::CNT_W-1:0]   row_lim,
  output logic [m2rs_pkg::CNT_W-1:0]   col_lim
);

  logic [m2rs_pkg::CNT_W-1:0] row_count;
  logic [m2rs_pkg::CNT_W-1:0] col_count;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= m2rs_pkg::CNT_RESET;
      col_count <= m2rs_pkg::CNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        m2rs_pkg::REG_ROW_COUNT: row_count <= pwdata[m2rs_pkg::CNT_W-1:0];
        m2rs_pkg::REG_COL_COUNT: col_count <= pwdata[m2rs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      m2rs_pkg::REG_ROW_COUNT:
        prdata = {{(m2rs_pkg::APB_DW-m2rs_pkg::CNT_W){1'b0}}, row_count};
      m2rs_pkg::REG_COL_COUNT:
        prdata = {{(m2rs_pkg::APB_DW-m2rs_pkg::CNT_W){1'b0}}, col_count};
      default: prdata = '0;
    endcase
  end

  // effective limit is min(count, max)
  assign row_lim = (32'(row_count) < m2rs_pkg::MAX_ROWS) ? row_count
                 : m2rs_pkg::CNT_W'(m2rs_pkg::MAX_ROWS);
  assign col_lim = (32'(col_count) < m2rs_pkg::MAX_COLS) ? col_count
                 : m2rs_pkg::CNT_W'(m2rs_pkg::MAX_COLS);

endmodule

### src/m2rs_dpath.sv
// datapath: request register, row/fenwick index counters, cell and fenwick
// rams, accumulator and result register; depends on m2rs_pkg and m2rs_ram
module m2rs_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  m2rs_pkg::ctl_t             ctl,
  output m2rs_pkg::sts_t             sts,
  input  m2rs_pkg::cmd_t             cmd,
  input  logic [m2rs_pkg::CNT_W-1:0] row_lim,
  input  logic [m2rs_pkg::CNT_W-1:0] col_lim,
  output logic                       res_valid,
  input  logic                       res_ready,
  output m2rs_pkg::res_t             res
);

  m2rs_pkg::cmd_t                   item;
  logic [m2rs_pkg::IDX_W-1:0]       r;
  logic [m2rs_pkg::K_W-1:0]         k;
  logic [m2rs_pkg::K_W-1:0]         k_low;
  logic [m2rs_pkg::K_W-1:0]         k_dn;
  logic [m2rs_pkg::ADDR_W-1:0]      clr_cnt;
  logic [m2rs_pkg::VAL_W:0]         delta;
  logic [m2rs_pkg::SUM_W-1:0]       acc;
  logic                             acc_en_q;
  logic                             sub_q;
  logic                             err_q;

  logic [m2rs_pkg::ADDR_W-1:0]      cell_addr;
  logic [m2rs_pkg::ADDR_W-1:0]      fen_addr;
  logic [m2rs_pkg::VAL_W-1:0]       cell_rdata;
  logic [m2rs_pkg::FEN_W-1:0]       fen_rdata;
  logic                             cell_we;
  logic [m2rs_pkg::ADDR_W-1:0]      cell_waddr;
  logic [m2rs_pkg::VAL_W-1:0]       cell_wdata;
  logic                             fen_we;
  logic [m2rs_pkg::ADDR_W-1:0]      fen_waddr;
  logic [m2rs_pkg::FEN_W-1:0]       fen_wdata;
  logic [m2rs_pkg::SUM_W-1:0]       fen_ext;
  logic [m2rs_pkg::CNT_W-1:0]       ra_x;
  logic [m2rs_pkg::CNT_W-1:0]       rb_x;
  logic [m2rs_pkg::CNT_W-1:0]       ca_x;
  logic [m2rs_pkg::CNT_W-1:0]       cb_x;

  assign k_low = k & (~k + m2rs_pkg::K_W'(1));
  assign k_dn  = k - k_low;

  assign cell_addr = {m2rs_pkg::ROW_W'(item.row_a), m2rs_pkg::COL_W'(item.col_a)};
  assign fen_addr  = {m2rs_pkg::ROW_W'(r), m2rs_pkg::COL_W'(k - m2rs_pkg::K_W'(1))};

  // clearing sweep overrides both write ports
  assign cell_we    = ctl.clr_step | ctl.cell_wr;
  assign cell_waddr = ctl.clr_step ? clr_cnt : cell_addr;
  assign cell_wdata = ctl.clr_step ? '0 : item.value;
  assign fen_we     = ctl.clr_step | ctl.fen_wr;
  assign fen_waddr  = ctl.clr_step ? clr_cnt : fen_addr;
  assign fen_wdata  = ctl.clr_step ? '0
                    : fen_rdata + {{(m2rs_pkg::FEN_W-m2rs_pkg::VAL_W-1){delta[m2rs_pkg::VAL_W]}},
                                   delta};

  m2rs_ram #(.WIDTH(m2rs_pkg::VAL_W), .DEPTH(m2rs_pkg::DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_addr),
    .rdata (cell_rdata)
  );

  m2rs_ram #(.WIDTH(m2rs_pkg::FEN_W), .DEPTH(m2rs_pkg::DEPTH)) u_fen_ram (
    .clk   (clk),
    .we    (fen_we),
    .waddr (fen_waddr),
    .wdata (fen_wdata),
    .raddr (fen_addr),
    .rdata (fen_rdata)
  );

  assign fen_ext = {{(m2rs_pkg::SUM_W-m2rs_pkg::FEN_W){fen_rdata[m2rs_pkg::FEN_W-1]}},
                    fen_rdata};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      acc_en_q  <= 1'b0;
      sub_q     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ctl.clr_step) begin
        clr_cnt <= clr_cnt + m2rs_pkg::ADDR_W'(1);
      end
      acc_en_q <= ctl.fen_rd;
      sub_q    <= ctl.fen_sub;
      if (ctl.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      item <= cmd;
    end
    if (ctl.row_init) begin
      r <= item.row_a;
    end else if (ctl.row_inc) begin
      r <= r + m2rs_pkg::IDX_W'(1);
    end
    if (ctl.k_hi_init) begin
      k <= m2rs_pkg::K_W'(item.col_b) + m2rs_pkg::K_W'(1);
    end else if (ctl.k_lo_init) begin
      k <= m2rs_pkg::K_W'(item.col_a);
    end else if (ctl.k_upd_init) begin
      k <= m2rs_pkg::K_W'(item.col_a) + m2rs_pkg::K_W'(1);
    end else if (ctl.k_down) begin
      k <= k_dn;
    end else if (ctl.k_up) begin
      k <= k + k_low;
    end
    if (ctl.delta_load) begin
      delta <= {item.value[m2rs_pkg::VAL_W-1], item.value}
             - {cell_rdata[m2rs_pkg::VAL_W-1], cell_rdata};
    end
    if (ctl.err_latch) begin
      err_q <= sts.q_err;
    end
    // ram read data is registered, so it arrives in the cycle after its read was issued
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (acc_en_q) begin
      acc <= sub_q ? acc - fen_ext : acc + fen_ext;
    end
    if (ctl.out_load) begin
      res.region_sum  <= acc;
      res.index_error <= err_q;
    end
  end

  assign ra_x = m2rs_pkg::CNT_W'(item.row_a);
  assign rb_x = m2rs_pkg::CNT_W'(item.row_b);
  assign ca_x = m2rs_pkg::CNT_W'(item.col_a);
  assign cb_x = m2rs_pkg::CNT_W'(item.col_b);

  always_comb begin
    sts.clr_last    = (clr_cnt == {m2rs_pkg::ADDR_W{1'b1}});
    sts.k_zero      = (k == '0);
    sts.k_next_zero = (k_dn == '0);
    sts.k_over      = (k > m2rs_pkg::K_W'(m2rs_pkg::MAX_COLS));
    sts.row_last    = (r == item.row_b);
    sts.q_err       = (ra_x >= row_lim) || (rb_x >= row_lim)
                   || (ca_x >= col_lim) || (cb_x >= col_lim);
    sts.q_empty     = (item.row_a > item.row_b) || (item.col_a > item.col_b);
    sts.u_err       = (ra_x >= row_lim) || (ca_x >= col_lim);
    sts.out_free    = !res_valid || res_ready;
  end

endmodule

### src/m2rs_ctrl.sv
// controller: clearing sweep, update walk and query walk sequencing
// depends on m2rs_pkg
module m2rs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_opcode,
  output logic           cmd_ready,
  input  m2rs_pkg::sts_t sts,
  output m2rs_pkg::ctl_t ctl
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_UPD_RD    = 4'd2;
  localparam logic [3:0] S_UPD_DELTA = 4'd3;
  localparam logic [3:0] S_UPD_FRD   = 4'd4;
  localparam logic [3:0] S_UPD_FWR   = 4'd5;
  localparam logic [3:0] S_Q_CHECK   = 4'd6;
  localparam logic [3:0] S_Q_HI      = 4'd7;
  localparam logic [3:0] S_Q_LO      = 4'd8;
  localparam logic [3:0] S_Q_DRAIN   = 4'd9;
  localparam logic [3:0] S_Q_FIN     = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.item_load = 1'b1;
          state_next = (cmd_opcode == m2rs_pkg::OP_QUERY) ? S_Q_CHECK : S_UPD_RD;
        end
      end
      // cell ram is reading the old value this cycle
      S_UPD_RD: begin
        if (sts.u_err) begin
          state_next = S_IDLE;
        end else begin
          ctl.row_init   = 1'b1;
          ctl.k_upd_init = 1'b1;
          state_next     = S_UPD_DELTA;
        end
      end
      S_UPD_DELTA: begin
        ctl.delta_load = 1'b1;
        ctl.cell_wr    = 1'b1;
        state_next     = S_UPD_FRD;
      end
      S_UPD_FRD: begin
        state_next = sts.k_over ? S_IDLE : S_UPD_FWR;
      end
      S_UPD_FWR: begin
        ctl.fen_wr = 1'b1;
        ctl.k_up   = 1'b1;
        state_next = S_UPD_FRD;
      end
      S_Q_CHECK: begin
        ctl.acc_clr   = 1'b1;
        ctl.err_latch = 1'b1;
        ctl.row_init  = 1'b1;
        ctl.k_hi_init = 1'b1;
        state_next    = (sts.q_err || sts.q_empty) ? S_Q_FIN : S_Q_HI;
      end
      // upper prefix walk, never empty since it starts at col_b + 1
      S_Q_HI: begin
        ctl.fen_rd = 1'b1;
        if (sts.k_next_zero) begin
          ctl.k_lo_init = 1'b1;
          state_next    = S_Q_LO;
        end else begin
          ctl.k_down = 1'b1;
        end
      end
      // lower prefix walk, subtracted
      S_Q_LO: begin
        if (!sts.k_zero) begin
          ctl.fen_rd  = 1'b1;
          ctl.fen_sub = 1'b1;
        end
        if (sts.k_zero || sts.k_next_zero) begin
          if (sts.row_last) begin
            state_next = S_Q_DRAIN;
          end else begin
            ctl.row_inc   = 1'b1;
            ctl.k_hi_init = 1'b1;
            state_next    = S_Q_HI;
          end
        end else begin
          ctl.k_down = 1'b1;
        end
      end
      S_Q_DRAIN: begin
        state_next = S_Q_FIN;
      end
      S_Q_FIN: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/mutable_2d_range_sum.sv
// top level of the two-dimensional fenwick range sum block
// depends on m2rs_pkg, m2rs_regs, m2rs_ctrl and m2rs_dpath
//
//   channel  signals                          direction  carries
//   cmd      cmd_valid / cmd_ready / cmd      in         update or query request
//   res      res_valid / res_ready / res      out        region_sum, index_error
//   apb      psel penable pwrite paddr ...    in/out     row_count (0x0), col_count (0x4)
//
// after reset both rams are swept to zero, one entry a cycle over all 4096 entries, with
// cmd_ready low; config writes are taken meanwhile. update: reads the old cell, writes
// the new value and forms the delta, then reads and writes back each fenwick node it
// touches in the row. query: per row, adds one fenwick read per set bit of col_b+1,
// then subtracts one per set bit of col_a; one fenwick ram read port serializes these.
// a finished result sits in the output register; a following query stalls only
// at its end while that register is still full.
module mutable_2d_range_sum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  m2rs_pkg::cmd_t               cmd,
  output logic                         res_valid,
  input  logic                         res_ready,
  output m2rs_pkg::res_t               res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [m2rs_pkg::APB_AW-1:0]  paddr,
  input  logic [m2rs_pkg::APB_DW-1:0]  pwdata,
  output logic [m2rs_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  logic [m2rs_pkg::CNT_W-1:0] row_lim;
  logic [m2rs_pkg::CNT_W-1:0] col_lim;
  m2rs_pkg::ctl_t             ctl;
  m2rs_pkg::sts_t             sts;

  m2rs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .row_lim (row_lim),
    .col_lim (col_lim)
  );

  m2rs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_opcode (cmd.opcode),
    .cmd_ready  (cmd_ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  m2rs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cmd       (cmd),
    .row_lim   (row_lim),
    .col_lim   (col_lim),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

### bench/tb_mutable_2d_range_sum.sv
// testbench for mutable_2d_range_sum: drives update and query requests with random
// idling on both channels, predicts every region sum from a shadow copy of the matrix
// depends on m2rs_pkg and the mutable_2d_range_sum top level
module tb_mutable_2d_range_sum;

  localparam int UPDATE_SETTLE = 40;       // an update may still be walking its row
  localparam int LONG_HOLD     = 3000;
  localparam int PHASE_ITEMS   = 90;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int PRINT_LIMIT   = 40;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  m2rs_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  m2rs_pkg::res_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [m2rs_pkg::APB_AW-1:0] paddr = '0;
  logic [m2rs_pkg::APB_DW-1:0] pwdata = '0;
  logic [m2rs_pkg::APB_DW-1:0] prdata;
  logic pready;

  // shadow of the block's matrix and size registers
  logic signed [m2rs_pkg::VAL_W-1:0] cell_shadow [m2rs_pkg::MAX_ROWS][m2rs_pkg::MAX_COLS];
  logic [m2rs_pkg::CNT_W-1:0] rows_cfg;
  logic [m2rs_pkg::CNT_W-1:0] cols_cfg;
  m2rs_pkg::res_t expected_sums [$];

  int error_count = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;
  bit long_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  mutable_2d_range_sum dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mutable_2d_range_sum verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic int row_limit();
    return (int'(rows_cfg) < m2rs_pkg::MAX_ROWS) ? int'(rows_cfg) : m2rs_pkg::MAX_ROWS;
  endfunction

  function automatic int col_limit();
    return (int'(cols_cfg) < m2rs_pkg::MAX_COLS) ? int'(cols_cfg) : m2rs_pkg::MAX_COLS;
  endfunction

  // applies one request to the shadow matrix and works out its region sum
  function automatic void shadow_apply(input m2rs_pkg::cmd_t c, output bit gives_sum,
                                       output m2rs_pkg::res_t r);
    int rl;
    int cl;
    int i;
    int j;
    longint acc;
    rl = row_limit();
    cl = col_limit();
    gives_sum = 1'b0;
    r = '0;
    if (c.opcode == m2rs_pkg::OP_UPDATE) begin
      if (int'(c.row_a) < rl && int'(c.col_a) < cl)
        cell_shadow[c.row_a][c.col_a] = c.value;
    end else begin
      gives_sum = 1'b1;
      // range error wins over an empty range
      if (int'(c.row_a) >= rl || int'(c.row_b) >= rl ||
          int'(c.col_a) >= cl || int'(c.col_b) >= cl) begin
        r.index_error = 1'b1;
      end else if (c.row_a <= c.row_b && c.col_a <= c.col_b) begin
        acc = 0;
        for (i = int'(c.row_a); i <= int'(c.row_b); i++)
          for (j = int'(c.col_a); j <= int'(c.col_b); j++)
            acc += cell_shadow[i][j];
        r.region_sum = acc[m2rs_pkg::SUM_W-1:0];
      end
    end
  endfunction

  always @(posedge clk) begin
    m2rs_pkg::res_t want;
    if (rst === 1'b0 && res_valid === 1'b1 && res_ready === 1'b1) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("unrequested result", 64'(res.region_sum), 64'(0));
      end else begin
        want = expected_sums.pop_front();
        if (res.region_sum !== want.region_sum)
          report_mismatch("region_sum", 64'(res.region_sum), 64'(want.region_sum));
        if (res.index_error !== want.index_error)
          report_mismatch("index_error", 64'(res.index_error), 64'(want.index_error));
      end
    end
  end

  // result side: stall modes change every so often, plus a long hold on request
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_left;
    logic [15:0] pattern;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    pattern = '1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
        pattern = 16'($urandom);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        case (mode)
          0: res_ready <= 1'b1;
          1: res_ready <= 1'($urandom_range(0, 1));
          2: res_ready <= ($urandom_range(0, 7) == 0);
          default: begin
            res_ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
          end
        endcase
      end
    end
  end

  // one apb transfer; psel stays high so transfers can run back to back
  task automatic apb_transfer(input bit is_write, input logic reg_sel,
                              input logic [m2rs_pkg::APB_DW-1:0] wdata,
                              output logic [m2rs_pkg::APB_DW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {reg_sel, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
  endtask

  task automatic apb_idle();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_sizes();
    logic [m2rs_pkg::APB_DW-1:0] rd;
    apb_transfer(1'b0, m2rs_pkg::REG_ROW_COUNT, '0, rd);
    if (rd !== m2rs_pkg::APB_DW'(rows_cfg))
      report_mismatch("row_count readback", 64'(rd), 64'(rows_cfg));
    apb_transfer(1'b0, m2rs_pkg::REG_COL_COUNT, '0, rd);
    if (rd !== m2rs_pkg::APB_DW'(cols_cfg))
      report_mismatch("col_count readback", 64'(rd), 64'(cols_cfg));
    apb_idle();
  endtask

  // drop valid, wait for every pending sum, then let a trailing update finish
  task automatic settle_block();
    cmd_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (UPDATE_SETTLE) @(posedge clk);
  endtask

  task automatic set_sizes(input logic [m2rs_pkg::APB_DW-1:0] rows_word,
                           input logic [m2rs_pkg::APB_DW-1:0] cols_word);
    logic [m2rs_pkg::APB_DW-1:0] rd;
    settle_block();
    apb_transfer(1'b1, m2rs_pkg::REG_ROW_COUNT, rows_word, rd);
    apb_transfer(1'b1, m2rs_pkg::REG_COL_COUNT, cols_word, rd);
    rows_cfg = rows_word[m2rs_pkg::CNT_W-1:0];
    cols_cfg = cols_word[m2rs_pkg::CNT_W-1:0];
    check_sizes();
  endtask

  task automatic send_request(input m2rs_pkg::cmd_t c);
    int gap;
    bit gives_sum;
    m2rs_pkg::res_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_ready !== 1'b1) @(posedge clk);
    shadow_apply(c, gives_sum, r);
    if (gives_sum) expected_sums = {expected_sums, r};
  endtask

  task automatic send_update(input int row, input int col,
                             input logic [m2rs_pkg::VAL_W-1:0] val);
    m2rs_pkg::cmd_t c;
    c.opcode = m2rs_pkg::OP_UPDATE;
    c.row_a = m2rs_pkg::IDX_W'(row);
    c.col_a = m2rs_pkg::IDX_W'(col);
    c.row_b = m2rs_pkg::IDX_W'($urandom);
    c.col_b = m2rs_pkg::IDX_W'($urandom);
    c.value = val;
    send_request(c);
  endtask

  task automatic send_query(input int ra, input int ca, input int rb, input int cb);
    m2rs_pkg::cmd_t c;
    c.opcode = m2rs_pkg::OP_QUERY;
    c.row_a = m2rs_pkg::IDX_W'(ra);
    c.col_a = m2rs_pkg::IDX_W'(ca);
    c.row_b = m2rs_pkg::IDX_W'(rb);
    c.col_b = m2rs_pkg::IDX_W'(cb);
    c.value = $urandom;
    send_request(c);
  endtask

  // mostly inside the configured size, now and then anywhere
  function automatic logic [m2rs_pkg::IDX_W-1:0] pick_index(input int lim);
    if (lim == 0 || $urandom_range(0, 9) == 0)
      return m2rs_pkg::IDX_W'($urandom_range(0, (1 << m2rs_pkg::IDX_W) - 1));
    return m2rs_pkg::IDX_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [m2rs_pkg::VAL_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic m2rs_pkg::cmd_t random_request();
    m2rs_pkg::cmd_t c;
    int shape;
    logic [m2rs_pkg::IDX_W-1:0] t;
    c.opcode = ($urandom_range(0, 1) == 1) ? m2rs_pkg::OP_QUERY : m2rs_pkg::OP_UPDATE;
    c.row_a = pick_index(row_limit());
    c.col_a = pick_index(col_limit());
    c.row_b = pick_index(row_limit());
    c.col_b = pick_index(col_limit());
    c.value = random_value();
    shape = $urandom_range(0, 9);
    if (c.opcode == m2rs_pkg::OP_QUERY && shape < 8) begin
      if (c.row_a > c.row_b) begin
        t = c.row_a; c.row_a = c.row_b; c.row_b = t;
      end
      if (c.col_a > c.col_b) begin
        t = c.col_a; c.col_a = c.col_b; c.col_b = t;
      end
      // short row spans keep most queries fast
      if (shape < 6 && c.row_b - c.row_a > 3)
        c.row_b = m2rs_pkg::IDX_W'(c.row_a + $urandom_range(0, 3));
    end else if (c.opcode == m2rs_pkg::OP_QUERY && shape == 8) begin
      if (c.row_a < c.row_b) begin
        t = c.row_a; c.row_a = c.row_b; c.row_b = t;
      end
    end
    return c;
  endfunction

  task automatic test_register_reset();
    check_sizes();
  endtask

  task automatic test_value_extremes();
    send_update(0, 0, 32'h7FFF_FFFF);
    send_update(0, 63, 32'h8000_0000);
    send_update(63, 0, 32'hFFFF_FFFF);
    send_update(63, 63, 32'h8000_0000);
    send_update(31, 32, 32'h5555_5555);
    send_update(32, 31, 32'hAAAA_AAAA);
    send_query(0, 0, 0, 0);
    send_query(0, 0, 63, 63);
    send_query(63, 63, 63, 63);
    send_query(0, 0, 0, 63);
    send_query(0, 63, 63, 63);
    send_query(5, 0, 4, 63);
    send_query(0, 63, 63, 0);
    send_update(0, 0, 32'h0000_0000);
    send_query(0, 0, 0, 0);
    send_update(0, 0, 32'h7FFF_FFFF);
    send_update(0, 1, 32'h7FFF_FFFF);
    send_query(0, 0, 0, 1);
  endtask

  task automatic test_index_limits();
    set_sizes(10, 20);
    send_query(9, 19, 9, 19);
    send_query(10, 0, 10, 0);
    send_query(0, 20, 0, 20);
    send_query(0, 0, 10, 19);
    send_query(0, 0, 9, 20);
    send_query(9, 19, 0, 0);
    send_query(10, 5, 3, 2);
    send_update(10, 5, 123);
    send_update(5, 20, 456);
    send_update(9, 19, -7);
    send_query(0, 0, 9, 19);
    set_sizes(64, 64);
    send_query(10, 5, 10, 5);
    send_query(5, 20, 5, 20);
  endtask

  task automatic test_zero_and_oversize();
    set_sizes(0, 0);
    send_query(0, 0, 0, 0);
    send_update(0, 0, 99);
    set_sizes(0, 64);
    send_query(0, 0, 0, 0);
    // only the low seven bits land in the register
    set_sizes(32'hFFFF_FF7F, 32'h1234_56FF);
    send_query(0, 0, 0, 0);
    send_query(63, 63, 63, 63);
    send_query(0, 0, 63, 63);
  endtask

  task automatic test_random_traffic();
    int ph;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_sizes(64, 64);
        1: set_sizes(1, 1);
        2: set_sizes(1, 64);
        3: set_sizes(64, 1);
        default: set_sizes($urandom_range(1, 64), $urandom_range(1, 64));
      endcase
      sender_steady = (ph == 2);
      repeat (PHASE_ITEMS) send_request(random_request());
    end
    sender_steady = 1'b0;
  endtask

  task automatic test_result_backpressure();
    m2rs_pkg::cmd_t c;
    set_sizes(64, 64);
    sender_steady = 1'b1;
    long_hold_req = 1'b1;
    repeat (12) begin
      do c = random_request(); while (c.opcode != m2rs_pkg::OP_QUERY);
      send_request(c);
    end
    sender_steady = 1'b0;
    settle_block();
  endtask

  initial begin
    int i;
    int j;
    for (i = 0; i < m2rs_pkg::MAX_ROWS; i++)
      for (j = 0; j < m2rs_pkg::MAX_COLS; j++)
        cell_shadow[i][j] = '0;
    rows_cfg = m2rs_pkg::CNT_RESET;
    cols_cfg = m2rs_pkg::CNT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_value_extremes();
    test_index_limits();
    test_zero_and_oversize();
    test_random_traffic();
    test_result_backpressure();
    settle_block();
    if (error_count == 0)
      $display("mutable_2d_range_sum verification clean");
    else
      $display("mutable_2d_range_sum verification failed");
    $finish;
  end

endmodule
